/* rtl/sbss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbss_pkg
// Shared types, keyword text and character helpers of the statement splitter.
// ----------------------------------------------------------------------------
package sbss_pkg;

	localparam int unsigned KEYWORD_WINDOW = 27;
	localparam int unsigned KW_MAX_LEN     = 27;

	localparam int unsigned KW_CF    = 0;
	localparam int unsigned KW_CORF  = 1;
	localparam int unsigned KW_CP    = 2;
	localparam int unsigned KW_CORP  = 3;
	localparam int unsigned KW_END   = 4;
	localparam int unsigned KW_COUNT = 5;

	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef logic [8*KW_MAX_LEN-1:0] kw_text_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} cell_t;

	typedef struct packed {
		logic push;
		logic clear;
	} cell_ctl_t;

	function automatic kw_text_t kw_text(input int unsigned k);
		kw_text_t t;
		case (k)
			KW_CF:   t = kw_text_t'("CREATE FUNCTION");
			KW_CORF: t = kw_text_t'("CREATE OR REPLACE FUNCTION");
			KW_CP:   t = kw_text_t'("CREATE PROCEDURE");
			KW_CORP: t = kw_text_t'("CREATE OR REPLACE PROCEDURE");
			KW_END:  t = kw_text_t'("END");
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic int unsigned kw_len(input int unsigned k);
		int unsigned n;
		case (k)
			KW_CF:   n = 15;
			KW_CORF: n = 26;
			KW_CP:   n = 16;
			KW_CORP: n = 27;
			KW_END:  n = 3;
			default: n = 0;
		endcase
		return n;
	endfunction

	// character d places before the keyword's last one (d = 0 is the last)
	function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned d);
		kw_text_t t;
		logic [7:0] ch;
		t  = kw_text(k);
		ch = 8'h00;
		if (d < KW_MAX_LEN) begin
			ch = t[8*d +: 8];
		end
		return ch;
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/sbss_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbss_in_if
// Request channel carrying raw batch text bytes.
// ----------------------------------------------------------------------------
interface sbss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       batch_end;

	modport source (output valid, output data_byte, output batch_end, input ready);
	modport sink   (input valid, input data_byte, input batch_end, output ready);
endinterface
`default_nettype wire

/* rtl/sbss_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbss_out_if
// Request channel carrying marked bytes and statement boundaries.
// ----------------------------------------------------------------------------
interface sbss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_kept;
	logic       statement_end;
	logic       statement_blank;

	modport source (output valid, output out_byte, output byte_kept, output statement_end,
		output statement_blank, input ready);
	modport sink   (input valid, input out_byte, input byte_kept, input statement_end,
		input statement_blank, output ready);
endinterface
`default_nettype wire

/* rtl/sbss_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbss_cell
// One place of the recent byte window: holds a byte, shifts it on to the next
// place and compares it against the keyword characters due at this offset.
// ----------------------------------------------------------------------------
module sbss_cell #(
	parameter int unsigned POS = 0
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire sbss_pkg::cell_ctl_t             ctl,
	input  wire sbss_pkg::cell_t                 prev,
	output sbss_pkg::cell_t                      cur,
	output logic [sbss_pkg::KW_COUNT-1:0]        hit
);

	logic       valid_q;
	logic [7:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.push) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= prev.data;
		end
	end

	assign cur.valid = valid_q;
	assign cur.data  = data_q;

	for (genvar k = 0; k < sbss_pkg::KW_COUNT; k++) begin : g_kw
		if (POS + 1 < sbss_pkg::kw_len(k)) begin : g_used
			assign hit[k] = valid_q &&
				(sbss_pkg::upcase(data_q) == sbss_pkg::kw_char(k, POS + 1));
		end else begin : g_free
			assign hit[k] = 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/sql_batch_statement_splitter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sql_batch_statement_splitter
// Takes one byte of SQL batch text per request and returns one marked byte
// per request: the byte (CR/LF in statement text outside quotes turned to
// space), whether it is statement text, whether it closes a statement and,
// at a close, whether the statement was blank. Quote, procedure and separator
// tracking lives in a few flags; keyword headers are found by a row of
// KEYWORD_WINDOW-1 cells holding the latest bytes of the statement, each
// comparing its byte in parallel. Throughput is one byte per clock from a
// single output register; input is held off only while that register is full
// and not being taken. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module sql_batch_statement_splitter #(
	parameter int unsigned KEYWORD_WINDOW = sbss_pkg::KEYWORD_WINDOW
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sbss_in_if.sink    text,
	sbss_out_if.source split
);

	localparam int unsigned HIST = KEYWORD_WINDOW - 1;

	logic in_quote_q, in_proc_q, closed_q, skip_q, seen_q;
	logic out_valid_q, out_kept_q, out_end_q, out_blank_q;
	logic [7:0] out_byte_q;

	logic       acc;
	logic [7:0] c;
	logic       last;

	sbss_pkg::cell_ctl_t                 ctl;
	sbss_pkg::cell_t     [HIST:0]        chain;
	logic [HIST-1:0][sbss_pkg::KW_COUNT-1:0] cell_hit;
	logic [sbss_pkg::KW_COUNT-1:0][HIST-1:0] hit_col;
	logic [sbss_pkg::KW_COUNT-1:0]           kw_hit;

	logic       in_quote_d, in_proc_d, closed_d, skip_d, seen_d;
	logic [7:0] ob_d;
	logic       kept_d, end_d, blank_d;
	logic       term, hdr, nonblank;

	assign c    = text.data_byte;
	assign last = text.batch_end;
	assign text.ready = !out_valid_q || split.ready;
	assign acc  = text.valid && text.ready;

	assign chain[0].valid = 1'b1;
	assign chain[0].data  = c;

	for (genvar i = 0; i < HIST; i++) begin : g_cell
		sbss_cell #(.POS(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prev   (chain[i]),
			.cur    (chain[i+1]),
			.hit    (cell_hit[i])
		);
		for (genvar k = 0; k < sbss_pkg::KW_COUNT; k++) begin : g_col
			assign hit_col[k][i] = cell_hit[i][k];
		end
	end

	for (genvar k = 0; k < sbss_pkg::KW_COUNT; k++) begin : g_match
		assign kw_hit[k] = (sbss_pkg::upcase(c) == sbss_pkg::kw_char(k, 0)) && (&hit_col[k]);
	end

	assign hdr = kw_hit[sbss_pkg::KW_CF] || kw_hit[sbss_pkg::KW_CORF] ||
		kw_hit[sbss_pkg::KW_CP] || kw_hit[sbss_pkg::KW_CORP];
	assign nonblank = (c != sbss_pkg::CH_SPACE) && (c != sbss_pkg::CH_TAB) &&
		(c != sbss_pkg::CH_CR) && (c != sbss_pkg::CH_LF);

	always_comb begin
		in_quote_d = in_quote_q;
		in_proc_d  = in_proc_q;
		closed_d   = closed_q;
		skip_d     = skip_q;
		seen_d     = seen_q;
		ob_d       = c;
		kept_d     = 1'b0;
		end_d      = 1'b0;
		blank_d    = 1'b0;
		term       = 1'b0;
		ctl.push   = 1'b0;
		ctl.clear  = 1'b0;
		if (skip_q) begin
			// drop the separator after a terminator
			skip_d = 1'b0;
		end else begin
			if (in_quote_q) begin
				if (c == sbss_pkg::CH_QUOTE) begin
					in_quote_d = 1'b0;
				end
			end else if (c == sbss_pkg::CH_QUOTE) begin
				in_quote_d = 1'b1;
			end else if (c == sbss_pkg::CH_SEMI && !in_proc_q && !closed_q) begin
				term = 1'b1;
			end else if (c == sbss_pkg::CH_SLASH && closed_q) begin
				term = 1'b1;
			end else begin
				if (hdr) begin
					in_proc_d = 1'b1;
				end else if (in_proc_q && kw_hit[sbss_pkg::KW_END]) begin
					in_proc_d = 1'b0;
					closed_d  = 1'b1;
				end
				if (c == sbss_pkg::CH_CR || c == sbss_pkg::CH_LF) begin
					ob_d = sbss_pkg::CH_SPACE;
				end
			end
			if (term) begin
				ob_d       = c;
				end_d      = 1'b1;
				blank_d    = !seen_q;
				in_quote_d = 1'b0;
				in_proc_d  = 1'b0;
				closed_d   = 1'b0;
				seen_d     = 1'b0;
				skip_d     = !last;
				ctl.clear  = 1'b1;
			end else begin
				seen_d   = seen_q || nonblank;
				kept_d   = 1'b1;
				end_d    = last;
				blank_d  = last && !seen_d;
				ctl.push = acc;
			end
		end
		if (last) begin
			// back to the reset state after the batch
			in_quote_d = 1'b0;
			in_proc_d  = 1'b0;
			closed_d   = 1'b0;
			seen_d     = 1'b0;
			skip_d     = 1'b0;
			ctl.clear  = 1'b1;
		end
		ctl.clear = ctl.clear && acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q  <= 1'b0;
			in_proc_q   <= 1'b0;
			closed_q    <= 1'b0;
			skip_q      <= 1'b0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				in_quote_q <= in_quote_d;
				in_proc_q  <= in_proc_d;
				closed_q   <= closed_d;
				skip_q     <= skip_d;
				seen_q     <= seen_d;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (split.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_byte_q  <= ob_d;
			out_kept_q  <= kept_d;
			out_end_q   <= end_d;
			out_blank_q <= blank_d;
		end
	end

	assign split.valid           = out_valid_q;
	assign split.out_byte        = out_byte_q;
	assign split.byte_kept       = out_kept_q;
	assign split.statement_end   = out_end_q;
	assign split.statement_blank = out_blank_q;

	a_end_empties_window: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_d |=> !chain[1].valid && !in_quote_q && !in_proc_q && !closed_q)
		else $error("window or flags not cleared at statement end");

	a_skip_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> !in_quote_q && !in_proc_q && !closed_q && !seen_q && !chain[1].valid)
		else $error("separator pending with statement state left over");

	a_blank_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_blank_q |-> out_end_q)
		else $error("blank flag outside a statement end");

endmodule
`default_nettype wire
